>>> src/mpsg_pkg.sv
// ---------------------------------------------------------------------------
// mpsg_pkg: shared types and constants for the motor pulse safety guard
// Request kinds, register indexes, field widths and the structs passed
// between the guard's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mpsg_pkg;

   // Field widths
   localparam int KIND_BITS      = 3;
   localparam int DUTY_BITS      = 8;
   localparam int CFG_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   // Tick counter width default
   localparam int TICK_COUNT_BITS_DEFAULT = 16;

   // Register reset values
   localparam logic [CFG_DATA_BITS-1:0] COOLDOWN_RESET = 16'd1000;
   localparam logic [CFG_DATA_BITS-1:0] MAX_ON_RESET   = 16'd5000;

   // Smallest duty driven by an accepted start
   localparam logic [DUTY_BITS-1:0] DUTY_MIN = 8'd1;

   // Request kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK   = 3'd0,
      KIND_ENABLE = 3'd1,
      KIND_START  = 3'd2,
      KIND_STOP   = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COOLDOWN = 1'd0,
      CSR_MAX_ON   = 1'd1
   } csr_index_type;

   // Configuration seen by the guard core
   typedef struct packed {
      logic [CFG_DATA_BITS-1:0] cooldown_ms;
      logic [CFG_DATA_BITS-1:0] max_on_ms;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [DUTY_BITS-1:0] duty_out;
      logic                 motor_on;
      logic                 locked_out;
      logic                 start_accepted;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/mpsg_channels.sv
// ---------------------------------------------------------------------------
// mpsg channels: valid/ready interfaces of the guard
// Request channel, result channel and register write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface mpsg_req_if;
   logic                           valid;
   logic                           ready;
   logic [mpsg_pkg::KIND_BITS-1:0] kind;
   logic [mpsg_pkg::DUTY_BITS-1:0] duty_request;

   modport source (output valid, output kind, output duty_request, input ready);
   modport sink   (input valid, input kind, input duty_request, output ready);
endinterface

interface mpsg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mpsg_pkg::DUTY_BITS-1:0] duty_out;
   logic                           motor_on;
   logic                           locked_out;
   logic                           start_accepted;

   modport source (output valid, output duty_out, output motor_on,
                   output locked_out, output start_accepted, input ready);
   modport sink   (input valid, input duty_out, input motor_on,
                   input locked_out, input start_accepted, output ready);
endinterface

interface mpsg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mpsg_pkg::CSR_INDEX_BITS-1:0] index;
   logic [mpsg_pkg::CFG_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/mpsg_csr_regs.sv
// ---------------------------------------------------------------------------
// mpsg_csr_regs: configuration registers
// Holds cooldown and maximum on time; writes are taken every cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mpsg_csr_regs (
   input  wire logic         clock,
   input  wire logic         reset,
   mpsg_csr_if.sink          csr_ch,
   output mpsg_pkg::cfg_type cfg
);

   mpsg_pkg::cfg_type cfg_ff;
   mpsg_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (mpsg_pkg::csr_index_type'(csr_ch.index))
            mpsg_pkg::CSR_COOLDOWN: cfg_in.cooldown_ms = csr_ch.data;
            mpsg_pkg::CSR_MAX_ON:   cfg_in.max_on_ms   = csr_ch.data;
            default:                cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_ms <= mpsg_pkg::COOLDOWN_RESET;
         cfg_ff.max_on_ms   <= mpsg_pkg::MAX_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/mpsg_guard_core.sv
// ---------------------------------------------------------------------------
// mpsg_guard_core: motor guard state and update logic
// Applies one request per cycle, when one is accepted, to the enable, run and
// lockout state and the saturating tick counters, and forms the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module mpsg_guard_core #(
   parameter int TICK_COUNT_BITS = mpsg_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [mpsg_pkg::KIND_BITS-1:0] kind,
   input  wire logic [mpsg_pkg::DUTY_BITS-1:0] duty_request,
   input  wire mpsg_pkg::cfg_type              cfg,
   output mpsg_pkg::rsp_type                   result
);

   // Compare width covers both counter and register
   localparam int CMP_BITS = (TICK_COUNT_BITS > mpsg_pkg::CFG_DATA_BITS) ?
                             TICK_COUNT_BITS : mpsg_pkg::CFG_DATA_BITS;
   localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

   logic                           enabled_ff,    enabled_in;
   logic                           running_ff,    running_in;
   logic                           lockout_ff,    lockout_in;
   logic [mpsg_pkg::DUTY_BITS-1:0] drive_duty_ff, drive_duty_in;
   logic [TICK_COUNT_BITS-1:0]     on_ticks_ff,   on_ticks_in;
   logic [TICK_COUNT_BITS-1:0]     off_ticks_ff,  off_ticks_in;

   logic [TICK_COUNT_BITS-1:0]     on_inc;
   logic [TICK_COUNT_BITS-1:0]     off_inc;
   logic [TICK_COUNT_BITS-1:0]     cooldown_sat;
   logic                           on_expired;
   logic                           cooled_down;
   logic                           accepted;
   logic [mpsg_pkg::DUTY_BITS-1:0] duty_clamped;

   // Saturating increments and compares
   assign on_inc       = (on_ticks_ff == TICK_MAX) ? on_ticks_ff : on_ticks_ff + 1'b1;
   assign off_inc      = (off_ticks_ff == TICK_MAX) ? off_ticks_ff : off_ticks_ff + 1'b1;
   assign on_expired   = CMP_BITS'(on_inc) >= CMP_BITS'(cfg.max_on_ms);
   assign cooled_down  = CMP_BITS'(off_ticks_ff) >= CMP_BITS'(cfg.cooldown_ms);
   assign cooldown_sat = (CMP_BITS'(cfg.cooldown_ms) > CMP_BITS'(TICK_MAX)) ?
                         TICK_MAX : TICK_COUNT_BITS'(cfg.cooldown_ms);
   assign duty_clamped = (duty_request < mpsg_pkg::DUTY_MIN) ?
                         mpsg_pkg::DUTY_MIN : duty_request;

   // Next state for the request
   always_comb begin
      enabled_in    = enabled_ff;
      running_in    = running_ff;
      lockout_in    = lockout_ff;
      drive_duty_in = drive_duty_ff;
      on_ticks_in   = on_ticks_ff;
      off_ticks_in  = off_ticks_ff;
      accepted      = 1'b0;
      case (mpsg_pkg::kind_type'(kind))
         mpsg_pkg::KIND_TICK: begin
            if (running_ff) begin
               on_ticks_in = on_inc;
               if (on_expired) begin
                  running_in    = 1'b0;
                  drive_duty_in = '0;
                  lockout_in    = 1'b1;
                  off_ticks_in  = '0;
               end
            end else begin
               off_ticks_in = off_inc;
            end
         end
         mpsg_pkg::KIND_ENABLE: begin
            enabled_in    = 1'b1;
            running_in    = 1'b0;
            lockout_in    = 1'b0;
            drive_duty_in = '0;
            on_ticks_in   = '0;
            off_ticks_in  = cooldown_sat;
         end
         mpsg_pkg::KIND_START: begin
            if (enabled_ff && !lockout_ff) begin
               if (running_ff) begin
                  accepted = 1'b1;
               end else if (cooled_down) begin
                  drive_duty_in = duty_clamped;
                  running_in    = 1'b1;
                  on_ticks_in   = '0;
                  accepted      = 1'b1;
               end
            end
         end
         mpsg_pkg::KIND_STOP: begin
            if (enabled_ff) begin
               drive_duty_in = '0;
               if (running_ff) begin
                  running_in   = 1'b0;
                  off_ticks_in = '0;
               end
            end
         end
         mpsg_pkg::KIND_CLEAR: begin
            lockout_in = 1'b0;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

   // State registers, updated per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         running_ff    <= 1'b0;
         lockout_ff    <= 1'b0;
         drive_duty_ff <= '0;
         on_ticks_ff   <= '0;
         off_ticks_ff  <= '0;
      end else if (accept) begin
         enabled_ff    <= enabled_in;
         running_ff    <= running_in;
         lockout_ff    <= lockout_in;
         drive_duty_ff <= drive_duty_in;
         on_ticks_ff   <= on_ticks_in;
         off_ticks_ff  <= off_ticks_in;
      end
   end

   // Result reflects the state after the request
   assign result.duty_out       = drive_duty_in;
   assign result.motor_on       = running_in;
   assign result.locked_out     = lockout_in;
   assign result.start_accepted = accepted;

   // Checks
   a_run_has_duty: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (drive_duty_ff != '0))
      else $error("motor running with zero duty");

   a_lock_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(lockout_ff) |-> $past(accept) &&
                            ($past(kind) == mpsg_pkg::KIND_TICK) && !running_ff)
      else $error("lockout set by something other than an expiring tick");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (accept && accepted) |=> running_ff && !lockout_ff && enabled_ff)
      else $error("accepted start left motor stopped");

   a_start_needs_enable: assert property (@(posedge clock) disable iff (reset)
      $rose(running_ff) |-> $past(enabled_ff) && !$past(lockout_ff))
      else $error("motor started while disabled or locked out");

endmodule

`default_nettype wire

>>> src/mpsg_rsp_stage.sv
// ---------------------------------------------------------------------------
// mpsg_rsp_stage: result register
// Holds one result item until taken; loads the next one in the same cycle
// the held one leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module mpsg_rsp_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire mpsg_pkg::rsp_type result,
   output logic                   space,
   mpsg_rsp_if.source             rsp_ch
);

   logic              valid_ff, valid_in;
   mpsg_pkg::rsp_type data_ff;

   // Room when empty or the held item leaves now
   assign space    = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.duty_out       = data_ff.duty_out;
   assign rsp_ch.motor_on       = data_ff.motor_on;
   assign rsp_ch.locked_out     = data_ff.locked_out;
   assign rsp_ch.start_accepted = data_ff.start_accepted;

endmodule

`default_nettype wire

>>> src/motor_pulse_safety_guard_unit.sv
// The guard takes one request per clock cycle while it has room and returns
// exactly one result per request, in the cycle after it is accepted, from a
// result register; a new request is taken in the same cycle a held result is
// taken, so with the result side always ready the rate is one request per
// cycle. The rate is set by the state update of the guard core.
// Register writes go through the csr channel, which is always ready.
// ---------------------------------------------------------------------------
// motor_pulse_safety_guard_unit: vibration motor PWM duty guard
// Enable, start, stop, tick and lockout-clear requests update the motor
// state; on-time limit forces the motor off and locks it out.
// ---------------------------------------------------------------------------
`default_nettype none

module motor_pulse_safety_guard_unit #(
   parameter int TICK_COUNT_BITS = mpsg_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mpsg_req_if.sink   req_ch,
   mpsg_rsp_if.source rsp_ch,
   mpsg_csr_if.sink   csr_ch
);

   mpsg_pkg::cfg_type cfg;
   mpsg_pkg::rsp_type result;
   logic              space;
   logic              req_accept;

   assign req_ch.ready = space;
   assign req_accept   = req_ch.valid && space;

   mpsg_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   mpsg_guard_core #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .kind         (req_ch.kind),
      .duty_request (req_ch.duty_request),
      .cfg          (cfg),
      .result       (result)
   );

   mpsg_rsp_stage u_rsp (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .result (result),
      .space  (space),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for the motor pulse safety guard
// Drives tick, enable, start, stop and lockout-clear requests into the guard,
// predicts the motor state in a behavioral model of the guard and checks
// every result field by field. Directed tests cover the corner cases, then
// random sessions run under several register settings with random stalls.
// ---------------------------------------------------------------------------
module tb;

   localparam int     TB_TICK_BITS  = mpsg_pkg::TICK_COUNT_BITS_DEFAULT;
   localparam longint TICK_LIMIT    = (64'd1 << TB_TICK_BITS) - 1;
   localparam int     KIND_W        = mpsg_pkg::KIND_BITS;
   localparam int     DUTY_W        = mpsg_pkg::DUTY_BITS;
   localparam int     CFG_W         = mpsg_pkg::CFG_DATA_BITS;
   localparam int     DRAIN_LIMIT   = 2000;
   localparam int     SETTLE_CYCLES = 4;
   localparam int     PHASE_ITEMS   = 300;
   localparam int     PHASE_COUNT   = 6;

   logic clock;
   logic reset;

   mpsg_req_if req_if ();
   mpsg_rsp_if rsp_if ();
   mpsg_csr_if csr_if ();

   motor_pulse_safety_guard_unit #(
      .TICK_COUNT_BITS(TB_TICK_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Guard model state and register copies
   logic                     model_enabled;
   logic                     model_running;
   logic                     model_lockout;
   logic [DUTY_W-1:0]        model_duty;
   logic [TB_TICK_BITS-1:0]  model_on_ticks;
   logic [TB_TICK_BITS-1:0]  model_off_ticks;
   logic [CFG_W-1:0]         model_cooldown;
   logic [CFG_W-1:0]         model_max_on;

   mpsg_pkg::rsp_type guard_expected_q[$];
   mpsg_pkg::rsp_type checked_rsp;
   int      mismatch_count = 0;
   int      requests_sent  = 0;
   bit      idle_on        = 1'b1;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard model: applies one request, queues the state it should report
   function automatic void guard_predict(logic [KIND_W-1:0] kind,
                                         logic [DUTY_W-1:0] duty);
      mpsg_pkg::rsp_type exp_rsp;
      logic    accepted;
      accepted = 1'b0;
      case (kind)
         mpsg_pkg::KIND_TICK: begin
            if (model_running) begin
               if (model_on_ticks != '1) model_on_ticks = model_on_ticks + 1'b1;
               if (model_on_ticks >= model_max_on) begin
                  // on-time limit: force off and lock out
                  model_running   = 1'b0;
                  model_duty      = '0;
                  model_lockout   = 1'b1;
                  model_off_ticks = '0;
               end
            end else if (model_off_ticks != '1) begin
               model_off_ticks = model_off_ticks + 1'b1;
            end
         end
         mpsg_pkg::KIND_ENABLE: begin
            model_enabled  = 1'b1;
            model_running  = 1'b0;
            model_lockout  = 1'b0;
            model_duty     = '0;
            model_on_ticks = '0;
            model_off_ticks = (longint'(model_cooldown) > TICK_LIMIT) ?
                              '1 : TB_TICK_BITS'(model_cooldown);
         end
         mpsg_pkg::KIND_START: begin
            if (model_enabled && !model_lockout) begin
               if (model_running) begin
                  accepted = 1'b1;
               end else if (model_off_ticks >= model_cooldown) begin
                  model_duty     = (duty == '0) ? mpsg_pkg::DUTY_MIN : duty;
                  model_running  = 1'b1;
                  model_on_ticks = '0;
                  accepted       = 1'b1;
               end
            end
         end
         mpsg_pkg::KIND_STOP: begin
            if (model_enabled) begin
               model_duty = '0;
               if (model_running) begin
                  model_running   = 1'b0;
                  model_off_ticks = '0;
               end
            end
         end
         mpsg_pkg::KIND_CLEAR: begin
            model_lockout = 1'b0;
         end
         default: ;
      endcase
      exp_rsp.duty_out       = model_duty;
      exp_rsp.motor_on       = model_running;
      exp_rsp.locked_out     = model_lockout;
      exp_rsp.start_accepted = accepted;
      guard_expected_q.push_back(exp_rsp);
   endfunction

   // Send one request, with an optional idle burst in front of it
   task automatic send_request(logic [KIND_W-1:0] kind, logic [DUTY_W-1:0] duty);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.duty_request <= duty;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      guard_predict(kind, duty);
      requests_sent++;
   endtask

   // Drop valid and wait until every result has come back
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (guard_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (guard_expected_q.size() != 0) begin
         $error("%0d results never arrived", guard_expected_q.size());
         mismatch_count++;
         guard_expected_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write
   task automatic write_csr(mpsg_pkg::csr_index_type index, logic [CFG_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (index)
         mpsg_pkg::CSR_COOLDOWN: model_cooldown = data;
         mpsg_pkg::CSR_MAX_ON:   model_max_on   = data;
         default: ;
      endcase
   endtask

   // Set both registers while the guard is idle
   task automatic configure(logic [CFG_W-1:0] cooldown,
                            logic [CFG_W-1:0] max_on);
      wait_idle();
      write_csr(mpsg_pkg::CSR_COOLDOWN, cooldown);
      write_csr(mpsg_pkg::CSR_MAX_ON, max_on);
      csr_if.valid <= 1'b0;
   endtask

   // Result side: random stall bursts while idling is on
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (guard_expected_q.size() == 0) begin
            $error("result with no request pending: duty_out %0d", rsp_if.duty_out);
            mismatch_count++;
         end else begin
            checked_rsp = guard_expected_q.pop_front();
            if (rsp_if.duty_out !== checked_rsp.duty_out) begin
               $error("duty_out: expected %0d, actual %0d",
                      checked_rsp.duty_out, rsp_if.duty_out);
               mismatch_count++;
            end
            if (rsp_if.motor_on !== checked_rsp.motor_on) begin
               $error("motor_on: expected %0d, actual %0d",
                      checked_rsp.motor_on, rsp_if.motor_on);
               mismatch_count++;
            end
            if (rsp_if.locked_out !== checked_rsp.locked_out) begin
               $error("locked_out: expected %0d, actual %0d",
                      checked_rsp.locked_out, rsp_if.locked_out);
               mismatch_count++;
            end
            if (rsp_if.start_accepted !== checked_rsp.start_accepted) begin
               $error("start_accepted: expected %0d, actual %0d",
                      checked_rsp.start_accepted, rsp_if.start_accepted);
               mismatch_count++;
            end
         end
      end
   end

   // Before enable: start refused, stop ignored, tick, clear and unused kinds
   task automatic test_before_enable();
      send_request(mpsg_pkg::KIND_START, 8'h80);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_CLEAR, 8'h00);
      send_request(3'd5, 8'hFF);
      send_request(3'd6, 8'h00);
      send_request(3'd7, 8'h55);
   endtask

   // Reset settings: clamp, restart while running, cooldown refusal
   task automatic test_start_stop();
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hC8);
      send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hFF);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hFF);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
   endtask

   // Max on time of zero and a short limit: forced off, lockout and clear
   task automatic test_on_time_limit();
      configure(16'd0, 16'd0);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h7F);
      send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h7F);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      send_request(mpsg_pkg::KIND_CLEAR, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h01);
      send_request(mpsg_pkg::KIND_CLEAR, 8'h00);
      send_request(mpsg_pkg::KIND_TICK, 8'h00);
      configure(16'd2, 16'd3);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h0A);
      repeat (3) send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_CLEAR, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h0A);
      repeat (2) send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hAA);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
   endtask

   // Largest register values: only starts right after an enable go through
   task automatic test_extreme_config();
      configure(16'hFFFF, 16'hFFFF);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hC8);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hC8);
      send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'hC8);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h33);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
   endtask

   // Off counter loaded at its ceiling by enable: ticks hold it there and a
   // start still goes through
   task automatic test_counter_saturation();
      idle_on = 1'b0;
      configure(16'hFFFF, 16'hFFFF);
      send_request(mpsg_pkg::KIND_ENABLE, 8'h00);
      repeat (4) send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h09);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      repeat (4) send_request(mpsg_pkg::KIND_TICK, 8'h00);
      send_request(mpsg_pkg::KIND_START, 8'h09);
      send_request(mpsg_pkg::KIND_STOP, 8'h00);
      wait_idle();
      idle_on = 1'b1;
   endtask

   // Random traffic: mostly enable/start/tick/stop sessions, some noise
   task automatic run_random_requests(int count);
      int target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(KIND_W'($urandom_range(0, 7)), DUTY_W'($urandom));
         end else begin
            if ($urandom_range(0, 2) == 0)
               send_request(mpsg_pkg::KIND_ENABLE, DUTY_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               send_request(mpsg_pkg::KIND_CLEAR, DUTY_W'($urandom));
            repeat ($urandom_range(0, 28))
               send_request(mpsg_pkg::KIND_TICK, DUTY_W'($urandom));
            send_request(mpsg_pkg::KIND_START,
                         ($urandom_range(0, 7) == 0) ? 8'h00 : DUTY_W'($urandom));
            if ($urandom_range(0, 4) == 0)
               send_request(mpsg_pkg::KIND_START, DUTY_W'($urandom));
            repeat ($urandom_range(0, 45))
               send_request(mpsg_pkg::KIND_TICK, DUTY_W'($urandom));
            if ($urandom_range(0, 2) != 0)
               send_request(mpsg_pkg::KIND_STOP, DUTY_W'($urandom));
         end
      end
   endtask

   // Random phases under changing settings; the last one without idling
   task automatic test_random_sessions();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) begin
            configure(16'd0, 16'd1);
         end else begin
            configure(CFG_W'($urandom_range(0, 24)), CFG_W'($urandom_range(0, 40)));
         end
         idle_on = (phase == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         run_random_requests(PHASE_ITEMS);
      end
   endtask

   // Main sequence
   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.kind         <= mpsg_pkg::KIND_TICK;
      req_if.duty_request <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= mpsg_pkg::CSR_COOLDOWN;
      csr_if.data         <= '0;
      model_enabled   = 1'b0;
      model_running   = 1'b0;
      model_lockout   = 1'b0;
      model_duty      = '0;
      model_on_ticks  = '0;
      model_off_ticks = '0;
      model_cooldown  = mpsg_pkg::COOLDOWN_RESET;
      model_max_on    = mpsg_pkg::MAX_ON_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_before_enable();
      test_start_stop();
      test_on_time_limit();
      test_extreme_config();
      test_counter_saturation();
      test_random_sessions();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
src/mpsg_pkg.sv
src/mpsg_channels.sv
src/mpsg_csr_regs.sv
src/mpsg_guard_core.sv
src/mpsg_rsp_stage.sv
src/motor_pulse_safety_guard_unit.sv
tb/tb.sv
